@@ rtl/fskr_pkg.sv @@
// ----------------------------------------------------------------------------
// fskr_pkg: shared definitions for the fence and separator key router
// Key widths, operation, direction and register codes, and the control
// structs that pass between the sequencer, the comparator and the store.
// ----------------------------------------------------------------------------
package fskr_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;

  localparam int KEY_W   = 64;
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int DIR_W   = 2;
  localparam int SEG_W   = 20;
  localparam int GATE_W  = 16;
  localparam int SEGS_W  = 5;
  localparam int CFG_IDX_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ROUTE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_AHEAD   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd2;
  localparam logic [DIR_W-1:0] DIR_INVALID = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SRC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SRC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGS     = 3'd5;

  // Outcome of one lexicographic key compare (a against b)
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  // Store access strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } sep_ctl_t;

endpackage

@@ rtl/fence_and_separator_key_router.sv @@
// ----------------------------------------------------------------------------
// fence_and_separator_key_router: routes 128-bit keys to gate segments
// Checks a key against the gate's low and high fences, then scans the stored
// separators with one shared comparator to pick the global segment number.
// Also writes and reads single separators.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  command   | start, busy               | operation_i, key_source_i,
//            |                           | key_destination_i, segment_position_i
//  result    | result_valid_o (1 cycle)  | direction_o, segment_number_o,
//            |                           | read_source_o, read_destination_o
//  config    | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A transaction is taken at a clock edge with start high and busy low; busy
// then stays high until the result is formed. A set, or a read at position
// zero or outside the window, ends in the execute state; a read in the window
// waits for the store's registered read. A route ends early when the gate is
// invalid or the key lies left of the low fence, else checks the high fence
// and then scans up to segments_in_use-1 separators one at a time, through
// the single key comparator and the one read port of the separator memory.
// The result strobe shows in the same cycle in which busy falls; the next
// transaction can be taken in that same cycle. The receiver cannot stall the result.
// Reset restores the sequencer and the configuration registers; separator
// entries read as the maximum key through per-entry valid bits, so no
// clearing pass is needed.
//
module fence_and_separator_key_router #(
  parameter int MAX_SEGMENTS = fskr_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command transaction
  input  logic                           start,
  output logic                           busy,
  input  logic [fskr_pkg::OP_W-1:0]      operation_i,
  input  logic [fskr_pkg::KEY_W-1:0]     key_source_i,
  input  logic [fskr_pkg::KEY_W-1:0]     key_destination_i,
  input  logic [fskr_pkg::POS_W-1:0]     segment_position_i,
  // result transaction
  output logic                           result_valid_o,
  output logic [fskr_pkg::DIR_W-1:0]     direction_o,
  output logic [fskr_pkg::SEG_W-1:0]     segment_number_o,
  output logic [fskr_pkg::KEY_W-1:0]     read_source_o,
  output logic [fskr_pkg::KEY_W-1:0]     read_destination_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [fskr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fskr_pkg::KEY_W-1:0]     cfg_data_i
);

  localparam int DEPTH  = MAX_SEGMENTS - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS);
  localparam int LEN_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int EXT_W  = (LEN_W > fskr_pkg::SEGS_W) ? LEN_W : fskr_pkg::SEGS_W;
  localparam int KEY_W  = fskr_pkg::KEY_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_HIGH   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;

  // Configuration registers
  logic [KEY_W-1:0]              low_src_q, low_dst_q, high_src_q, high_dst_q;
  logic [fskr_pkg::GATE_W-1:0]   gate_q;
  logic [fskr_pkg::SEGS_W-1:0]   segs_q;

  // Sequencer and transaction registers
  logic [2:0]                    state_q, state_d;
  logic [fskr_pkg::OP_W-1:0]     op_q;
  logic [KEY_W-1:0]              key_src_q, key_dst_q;
  logic [fskr_pkg::POS_W-1:0]    pos_q;
  logic [LEN_W-1:0]              len_q, len_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [fskr_pkg::SEG_W-1:0]    base_q;

  // Result registers
  logic                          res_valid_q, res_valid_d;
  logic [fskr_pkg::DIR_W-1:0]    dir_q, dir_d;
  logic [fskr_pkg::SEG_W-1:0]    seg_q, seg_d;
  logic [KEY_W-1:0]              rs_q, rs_d, rd_q, rd_d;

  // Shared comparator and store hookup
  logic [KEY_W-1:0]              cmp_a_src, cmp_a_dst, cmp_b_src, cmp_b_dst;
  fskr_pkg::cmp_t                cmp;
  fskr_pkg::sep_ctl_t            sep_ctl;
  logic [ADDR_W-1:0]             sep_wr_addr, sep_rd_addr;
  logic [KEY_W-1:0]              sep_src, sep_dst;

  logic                          accept;
  logic [EXT_W-1:0]              segs_ext;
  logic                          pos_in_window;
  logic                          low_is_max;
  logic [CNT_W-1:0]              cnt_inc;

  assign accept = start && !busy;
  assign busy   = state_q != ST_IDLE;

  // Clamp the window length into 1..MAX_SEGMENTS
  assign segs_ext = EXT_W'(segs_q);
  always_comb begin
    if (segs_ext == '0) begin
      len_d = LEN_W'(1);
    end else if (segs_ext > EXT_W'(MAX_SEGMENTS)) begin
      len_d = LEN_W'(MAX_SEGMENTS);
    end else begin
      len_d = LEN_W'(segs_ext);
    end
  end

  assign pos_in_window = EXT_W'(pos_q) < EXT_W'(len_q);
  assign low_is_max    = (&low_src_q) && (&low_dst_q);
  assign cnt_inc       = cnt_q + CNT_W'(1);

  // Comparator operands: key against a fence, or separator against key
  always_comb begin
    cmp_a_src = key_src_q;
    cmp_a_dst = key_dst_q;
    cmp_b_src = low_src_q;
    cmp_b_dst = low_dst_q;
    case (state_q)
      ST_HIGH: begin
        cmp_b_src = high_src_q;
        cmp_b_dst = high_dst_q;
      end
      ST_SCAN: begin
        cmp_a_src = sep_src;
        cmp_a_dst = sep_dst;
        cmp_b_src = key_src_q;
        cmp_b_dst = key_dst_q;
      end
      default: begin
      end
    endcase
  end

  fskr_key_cmp u_cmp (
    .a_src_i (cmp_a_src),
    .a_dst_i (cmp_a_dst),
    .b_src_i (cmp_b_src),
    .b_dst_i (cmp_b_dst),
    .cmp_o   (cmp)
  );

  fskr_sep_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sep_ctl),
    .wr_addr_i (sep_wr_addr),
    .wr_src_i  (key_src_q),
    .wr_dst_i  (key_dst_q),
    .rd_addr_i (sep_rd_addr),
    .rd_src_o  (sep_src),
    .rd_dst_o  (sep_dst)
  );

  // Position p lives at entry p-1
  assign sep_wr_addr = ADDR_W'(pos_q - fskr_pkg::POS_W'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    dir_d       = fskr_pkg::DIR_AHEAD;
    seg_d       = '0;
    rs_d        = '0;
    rd_d        = '0;
    sep_ctl     = '0;
    sep_rd_addr = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        res_valid_d = 1'b1;
        case (op_q)
          fskr_pkg::OP_ROUTE: begin
            if (low_is_max) begin
              dir_d = fskr_pkg::DIR_INVALID;
            end else if (cmp.lt) begin
              dir_d = fskr_pkg::DIR_LEFT;
            end else begin
              res_valid_d = 1'b0;
              state_d     = ST_HIGH;
            end
          end
          fskr_pkg::OP_SET: begin
            // Drop writes to position zero and outside the window
            sep_ctl.wr_en = pos_in_window && (pos_q != '0);
          end
          fskr_pkg::OP_READ: begin
            if (pos_q == '0) begin
              rs_d = low_src_q;
              rd_d = low_dst_q;
            end else if (pos_in_window) begin
              res_valid_d   = 1'b0;
              sep_ctl.rd_en = 1'b1;
              sep_rd_addr   = sep_wr_addr;
              state_d       = ST_RDWAIT;
            end else begin
              rs_d = '1;
              rd_d = '1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_HIGH: begin
        if (!(cmp.lt || cmp.eq)) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          dir_d       = fskr_pkg::DIR_RIGHT;
        end else if (len_q == LEN_W'(1)) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          seg_d       = base_q;
        end else begin
          // Fetch the first separator and start counting
          sep_ctl.rd_en = 1'b1;
          cnt_d         = '0;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp.lt || cmp.eq) begin
          cnt_d = cnt_inc;
          if (LEN_W'(cnt_q) + LEN_W'(2) < len_q) begin
            // Advance to the next separator
            sep_ctl.rd_en = 1'b1;
            sep_rd_addr   = ADDR_W'(cnt_inc);
          end else begin
            state_d     = ST_IDLE;
            res_valid_d = 1'b1;
            seg_d       = base_q + fskr_pkg::SEG_W'(cnt_inc);
          end
        end else begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          seg_d       = base_q + fskr_pkg::SEG_W'(cnt_q);
        end
      end
      ST_RDWAIT: begin
        state_d     = ST_IDLE;
        res_valid_d = 1'b1;
        rs_d        = sep_src;
        rd_d        = sep_dst;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      low_src_q   <= '1;
      low_dst_q   <= '1;
      high_src_q  <= '1;
      high_dst_q  <= '1;
      gate_q      <= '0;
      segs_q      <= fskr_pkg::SEGS_W'(16);
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          fskr_pkg::CFG_LOW_SRC:  low_src_q  <= cfg_data_i;
          fskr_pkg::CFG_LOW_DST:  low_dst_q  <= cfg_data_i;
          fskr_pkg::CFG_HIGH_SRC: high_src_q <= cfg_data_i;
          fskr_pkg::CFG_HIGH_DST: high_dst_q <= cfg_data_i;
          fskr_pkg::CFG_GATE:     gate_q     <= cfg_data_i[fskr_pkg::GATE_W-1:0];
          fskr_pkg::CFG_SEGS:     segs_q     <= cfg_data_i[fskr_pkg::SEGS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Transaction payload and results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      key_src_q <= key_source_i;
      key_dst_q <= key_destination_i;
      pos_q     <= segment_position_i;
      len_q     <= len_d;
    end
    if (state_q == ST_EXEC) begin
      // First segment of the gate, wrapped to the segment number width
      base_q <= fskr_pkg::SEG_W'(gate_q) * fskr_pkg::SEG_W'(len_q);
    end
    if (res_valid_d) begin
      dir_q <= dir_d;
      seg_q <= seg_d;
      rs_q  <= rs_d;
      rd_q  <= rd_d;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign direction_o        = dir_q;
  assign segment_number_o   = seg_q;
  assign read_source_o      = rs_q;
  assign read_destination_o = rd_q;

  // Scan never reads past the last separator of the window
  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> LEN_W'(cnt_q) + LEN_W'(1) < len_q)
    else $error("separator scan ran past the window");

  // A result follows only from work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) != ST_IDLE)
    else $error("result strobe without a transaction");

  // A taken transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("transaction taken but block not busy");

  // Non-ahead directions carry no segment number
  a_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && direction_o != fskr_pkg::DIR_AHEAD |-> segment_number_o == '0)
    else $error("segment number set without go ahead");

  // Store is never written while a route is in flight
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_HIGH) |-> !sep_ctl.wr_en)
    else $error("separator write during route");

endmodule

@@ rtl/fskr_key_cmp.sv @@
// ----------------------------------------------------------------------------
// fskr_key_cmp: shared 128-bit key comparator
// Compares two (source, destination) keys lexicographically, source first.
// ----------------------------------------------------------------------------
module fskr_key_cmp (
  input  logic [fskr_pkg::KEY_W-1:0] a_src_i,
  input  logic [fskr_pkg::KEY_W-1:0] a_dst_i,
  input  logic [fskr_pkg::KEY_W-1:0] b_src_i,
  input  logic [fskr_pkg::KEY_W-1:0] b_dst_i,
  output fskr_pkg::cmp_t             cmp_o
);

  logic src_lt;
  logic src_eq;
  logic dst_lt;
  logic dst_eq;

  assign src_lt = a_src_i < b_src_i;
  assign src_eq = a_src_i == b_src_i;
  assign dst_lt = a_dst_i < b_dst_i;
  assign dst_eq = a_dst_i == b_dst_i;

  // Destination half decides only on a tie in the source half
  assign cmp_o.lt = src_lt | (src_eq & dst_lt);
  assign cmp_o.eq = src_eq & dst_eq;

endmodule

@@ rtl/fskr_sep_store.sv @@
// ----------------------------------------------------------------------------
// fskr_sep_store: separator key memory
// One write port and one registered read port; per-entry valid bits make
// entries that were never written read as the maximum key.
// ----------------------------------------------------------------------------
module fskr_sep_store #(
  parameter int DEPTH  = fskr_pkg::MAX_SEGMENTS_DEF - 1,
  parameter int ADDR_W = $clog2(fskr_pkg::MAX_SEGMENTS_DEF - 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fskr_pkg::sep_ctl_t         ctl_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [fskr_pkg::KEY_W-1:0] wr_src_i,
  input  logic [fskr_pkg::KEY_W-1:0] wr_dst_i,
  input  logic [ADDR_W-1:0]          rd_addr_i,
  output logic [fskr_pkg::KEY_W-1:0] rd_src_o,
  output logic [fskr_pkg::KEY_W-1:0] rd_dst_o
);

  localparam int ENTRY_W = 2 * fskr_pkg::KEY_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= {wr_src_i, wr_dst_i};
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries hold the maximum key
  assign rd_src_o = rd_valid_q ? rd_data_q[ENTRY_W-1:fskr_pkg::KEY_W] : '1;
  assign rd_dst_o = rd_valid_q ? rd_data_q[fskr_pkg::KEY_W-1:0]       : '1;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fence and separator key router
// Drives route, set, read and unused commands through the start/busy port,
// predicts every result from a private copy of the fences, the gate setup and
// the separator store, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module tb;
  import fskr_pkg::*;

  localparam int SEG_LIMIT   = MAX_SEGMENTS_DEF;
  localparam int SCRIPT_ROWS = 24;
  localparam int GATE_SETUPS = 10;
  localparam int PER_SETUP   = 125;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOWHERE = 3'd7;
  localparam logic [KEY_W-1:0]     KEY_ZERO    = 64'h0;
  localparam logic [KEY_W-1:0]     KEY_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_src;
    logic [KEY_W-1:0] key_dst;
    logic [POS_W-1:0] position;
  } command_t;

  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic [SEG_W-1:0] segment;
    logic [KEY_W-1:0] src;
    logic [KEY_W-1:0] dst;
  } outcome_t;

  // One row of the directed script: gate setup it runs under, the command,
  // and an expected result where it is obvious by inspection.
  typedef struct packed {
    logic [1:0]       setup;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_src;
    logic [KEY_W-1:0] key_dst;
    logic [POS_W-1:0] position;
    logic             typed;
    logic [DIR_W-1:0] direction;
    logic [SEG_W-1:0] segment;
    logic [KEY_W-1:0] src;
    logic [KEY_W-1:0] dst;
  } script_row_t;

  // DUT connections
  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      operation_i;
  logic [KEY_W-1:0]     key_source_i;
  logic [KEY_W-1:0]     key_destination_i;
  logic [POS_W-1:0]     segment_position_i;
  logic                 result_valid_o;
  logic [DIR_W-1:0]     direction_o;
  logic [SEG_W-1:0]     segment_number_o;
  logic [KEY_W-1:0]     read_source_o;
  logic [KEY_W-1:0]     read_destination_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [KEY_W-1:0]     cfg_data_i;

  // Private copy of the gate: fences, setup and separator store
  logic [2*KEY_W-1:0] low_fence;
  logic [2*KEY_W-1:0] high_fence;
  logic [GATE_W-1:0]  gate_index;
  logic [SEGS_W-1:0]  window_reg;
  logic [2*KEY_W-1:0] separators [1:SEG_LIMIT-1];

  outcome_t    outcomes_due [$];
  script_row_t script [SCRIPT_ROWS];

  int mismatch_count;
  int results_checked;
  int commands_sent;
  int op_count [4];
  int dir_count [4];
  int setups_written;
  int quiet_cycles;

  fence_and_separator_key_router uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .operation_i        (operation_i),
    .key_source_i       (key_source_i),
    .key_destination_i  (key_destination_i),
    .segment_position_i (segment_position_i),
    .result_valid_o     (result_valid_o),
    .direction_o        (direction_o),
    .segment_number_o   (segment_number_o),
    .read_source_o      (read_source_o),
    .read_destination_o (read_destination_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Work out the result of one command and advance the separator store.
  // Keys compare as one 128-bit unsigned value: source is the major half.
  function automatic outcome_t gate_outcome(command_t c);
    outcome_t           o;
    logic [2*KEY_W-1:0] key;
    int                 wlen;
    int                 hits;
    o    = '0;
    key  = {c.key_src, c.key_dst};
    // A window of zero acts as one, anything past the store size saturates
    wlen = int'(window_reg);
    if (wlen == 0) wlen = 1;
    if (wlen > SEG_LIMIT) wlen = SEG_LIMIT;
    case (c.op)
      OP_ROUTE: begin
        if (low_fence == '1) begin
          o.direction = DIR_INVALID;
        end else if (key < low_fence) begin
          o.direction = DIR_LEFT;
        end else if (key > high_fence) begin
          o.direction = DIR_RIGHT;
        end else begin
          // Count leading separators at or below the key
          hits = 0;
          while (hits + 1 < wlen && separators[hits+1] <= key) hits++;
          o.direction = DIR_AHEAD;
          o.segment   = SEG_W'(int'(gate_index) * wlen + hits);
        end
      end
      OP_SET: begin
        // Position zero belongs to the low fence; out-of-window sets drop
        if (c.position != 0 && c.position < wlen) separators[c.position] = key;
      end
      OP_READ: begin
        if (c.position == 0) {o.src, o.dst} = low_fence;
        else if (c.position < wlen) {o.src, o.dst} = separators[c.position];
        else {o.src, o.dst} = '1;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Pick a key half close to a base so that keys, fences and separators
  // collide often; now and then take an edge value or a fully random one.
  function automatic logic [KEY_W-1:0] near_value(logic [KEY_W-1:0] base);
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return {$urandom, $urandom};
      1: return KEY_ZERO;
      2: return KEY_ONES;
      default: return base + KEY_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic command_t random_command(logic [KEY_W-1:0] base_src,
                                              logic [KEY_W-1:0] base_dst);
    command_t c;
    int       pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) c.op = OP_ROUTE;
    else if (pick < 14) c.op = OP_SET;
    else if (pick < 19) c.op = OP_READ;
    else c.op = OP_UNUSED;
    c.key_src  = near_value(base_src);
    c.key_dst  = near_value(base_dst);
    c.position = POS_W'($urandom_range(0, 15));
    return c;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, what);
    mismatch_count++;
  endtask

  // Drop start and hold until every outstanding result has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Drop start for a number of cycles; zero keeps the burst going
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Write the whole gate setup while the block is idle. Upper data bits of
  // the narrow registers carry noise, and a write to an unmapped index rides
  // along, since both must leave the gate untouched.
  task automatic program_gate(logic [2*KEY_W-1:0] low, logic [2*KEY_W-1:0] high,
                              logic [GATE_W-1:0] gate, logic [SEGS_W-1:0] segs);
    logic [KEY_W-1:0] noise;
    hold_until_drained();
    for (int idx = 0; idx < 7; idx++) begin
      noise    = {$urandom, $urandom};
      cfg_we_i <= 1'b1;
      case (idx)
        0: begin cfg_index_i <= CFG_LOW_SRC;  cfg_data_i <= low[2*KEY_W-1:KEY_W];  end
        1: begin cfg_index_i <= CFG_LOW_DST;  cfg_data_i <= low[KEY_W-1:0];        end
        2: begin cfg_index_i <= CFG_HIGH_SRC; cfg_data_i <= high[2*KEY_W-1:KEY_W]; end
        3: begin cfg_index_i <= CFG_HIGH_DST; cfg_data_i <= high[KEY_W-1:0];       end
        4: begin
          cfg_index_i <= CFG_GATE;
          cfg_data_i  <= {noise[KEY_W-1:GATE_W], gate};
        end
        5: begin
          cfg_index_i <= CFG_SEGS;
          cfg_data_i  <= {noise[KEY_W-1:SEGS_W], segs};
        end
        default: begin cfg_index_i <= CFG_NOWHERE; cfg_data_i <= noise; end
      endcase
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    low_fence  = low;
    high_fence = high;
    gate_index = gate;
    window_reg = segs;
    setups_written++;
  endtask

  // Present one command, hold it until the block takes it, then queue the
  // expected result. A typed expectation overrides the predictor, which
  // still runs so the separator store keeps in step.
  task automatic issue(command_t c, logic typed, outcome_t want);
    outcome_t o;
    start              <= 1'b1;
    operation_i        <= c.op;
    key_source_i       <= c.key_src;
    key_destination_i  <= c.key_dst;
    segment_position_i <= c.position;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    o = gate_outcome(c);
    if (typed) o = want;
    outcomes_due.push_back(o);
    commands_sent++;
    op_count[c.op]++;
    if (c.op == OP_ROUTE) dir_count[o.direction]++;
  endtask

  // Check every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      results_checked++;
      if (outcomes_due.size() == 0) begin
        flag_mismatch("result strobe with no command outstanding");
      end else begin
        want = outcomes_due.pop_front();
        if (direction_o !== want.direction)
          flag_mismatch($sformatf("direction %0d, want %0d", direction_o, want.direction));
        if (segment_number_o !== want.segment)
          flag_mismatch($sformatf("segment_number %0d, want %0d",
                                  segment_number_o, want.segment));
        if (read_source_o !== want.src)
          flag_mismatch($sformatf("read_source %h, want %h", read_source_o, want.src));
        if (read_destination_o !== want.dst)
          flag_mismatch($sformatf("read_destination %h, want %h",
                                  read_destination_o, want.dst));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]         cur_setup;
    logic [KEY_W-1:0]   base_src;
    logic [KEY_W-1:0]   base_dst;
    logic [2*KEY_W-1:0] low;
    logic [2*KEY_W-1:0] high;
    logic [2*KEY_W-1:0] swap;
    logic [SEGS_W-1:0]  segs;
    int                 burst;
    command_t           cmd;
    outcome_t           want;

    // Hold every input at a known value and keep reset asserted
    rst_ni             <= 1'b0;
    start              <= 1'b0;
    operation_i        <= OP_ROUTE;
    key_source_i       <= KEY_ZERO;
    key_destination_i  <= KEY_ZERO;
    segment_position_i <= '0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= CFG_LOW_SRC;
    cfg_data_i         <= KEY_ZERO;

    low_fence  = '1;
    high_fence = '1;
    gate_index = '0;
    window_reg = SEGS_W'(SEG_LIMIT);
    for (int p = 1; p < SEG_LIMIT; p++) separators[p] = '1;
    mismatch_count  = 0;
    results_checked = 0;
    commands_sent   = 0;
    setups_written  = 0;
    quiet_cycles    = 0;
    for (int k = 0; k < 4; k++) begin
      op_count[k]  = 0;
      dir_count[k] = 0;
    end

    // Directed script. Setup 0 is the reset state (fences all ones, so the
    // gate is invalid); setup 1 is a plain window of sixteen with three
    // separators; setup 2 drops the window to one through a zero count with
    // the widest fences and top gate; setup 3 saturates an oversized count.
    script[0]  = {2'd0, OP_ROUTE, KEY_ZERO, KEY_ZERO, 4'd0, 1'b1,
                  DIR_INVALID, 20'd0, KEY_ZERO, KEY_ZERO};
    script[1]  = {2'd0, OP_ROUTE, KEY_ONES, KEY_ONES, 4'd15, 1'b1,
                  DIR_INVALID, 20'd0, KEY_ZERO, KEY_ZERO};
    script[2]  = {2'd0, OP_READ, KEY_ZERO, KEY_ZERO, 4'd0, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ONES, KEY_ONES};
    script[3]  = {2'd0, OP_READ, KEY_ONES, KEY_ONES, 4'd15, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ONES, KEY_ONES};
    script[4]  = {2'd0, OP_UNUSED, KEY_ONES, KEY_ONES, 4'd15, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[5]  = {2'd1, OP_SET, 64'h20, KEY_ZERO, 4'd1, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[6]  = {2'd1, OP_SET, 64'h30, 64'h5, 4'd2, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[7]  = {2'd1, OP_SET, 64'hE0, KEY_ZERO, 4'd15, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[8]  = {2'd1, OP_SET, 64'h99, KEY_ZERO, 4'd0, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[9]  = {2'd1, OP_READ, KEY_ZERO, KEY_ZERO, 4'd0, 1'b1,
                  DIR_AHEAD, 20'd0, 64'h10, KEY_ZERO};
    script[10] = {2'd1, OP_READ, KEY_ZERO, KEY_ZERO, 4'd2, 1'b1,
                  DIR_AHEAD, 20'd0, 64'h30, 64'h5};
    script[11] = {2'd1, OP_ROUTE, 64'h0F, KEY_ONES, 4'd0, 1'b1,
                  DIR_LEFT, 20'd0, KEY_ZERO, KEY_ZERO};
    script[12] = {2'd1, OP_ROUTE, 64'hF1, KEY_ZERO, 4'd0, 1'b1,
                  DIR_RIGHT, 20'd0, KEY_ZERO, KEY_ZERO};
    script[13] = {2'd1, OP_ROUTE, 64'h10, KEY_ZERO, 4'd0, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[14] = {2'd1, OP_ROUTE, 64'h30, 64'h5, 4'd7, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[15] = {2'd1, OP_ROUTE, 64'hF0, KEY_ONES, 4'd0, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[16] = {2'd2, OP_SET, KEY_ZERO, KEY_ZERO, 4'd1, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[17] = {2'd2, OP_READ, KEY_ZERO, KEY_ZERO, 4'd1, 1'b1,
                  DIR_AHEAD, 20'd0, KEY_ONES, KEY_ONES};
    script[18] = {2'd2, OP_ROUTE, KEY_ZERO, KEY_ZERO, 4'd0, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[19] = {2'd2, OP_ROUTE, KEY_ONES, KEY_ONES, 4'd0, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[20] = {2'd3, OP_READ, KEY_ZERO, KEY_ZERO, 4'd15, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[21] = {2'd3, OP_ROUTE, 64'h100, KEY_ZERO, 4'd0, 1'b0,
                  DIR_AHEAD, 20'd0, KEY_ZERO, KEY_ZERO};
    script[22] = {2'd3, OP_ROUTE, 64'h5, 64'h4, 4'd0, 1'b1,
                  DIR_LEFT, 20'd0, KEY_ZERO, KEY_ZERO};
    script[23] = {2'd3, OP_ROUTE, 64'h100, 64'h1, 4'd0, 1'b1,
                  DIR_RIGHT, 20'd0, KEY_ZERO, KEY_ZERO};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script, reprogramming the gate at each new setup
    cur_setup = 2'd0;
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].setup != cur_setup) begin
        cur_setup = script[r].setup;
        case (cur_setup)
          2'd1: program_gate({64'h10, KEY_ZERO}, {64'hF0, KEY_ONES}, 16'd3, 5'd16);
          2'd2: program_gate({KEY_ZERO, KEY_ZERO}, {KEY_ONES, KEY_ONES}, 16'hFFFF, 5'd0);
          default: program_gate({64'h5, 64'h5}, {64'h100, KEY_ZERO}, 16'hFFFF, 5'd31);
        endcase
      end
      cmd  = {script[r].op, script[r].key_src, script[r].key_dst, script[r].position};
      want = {script[r].direction, script[r].segment, script[r].src, script[r].dst};
      issue(cmd, script[r].typed, want);
      pause_sender($urandom_range(0, 3));
    end

    // Random setups: fences and separators sit in a narrow band around a
    // per-setup base so compares land on both sides and on equality.
    for (int s = 0; s < GATE_SETUPS; s++) begin
      base_src = {$urandom, $urandom};
      base_dst = {$urandom, $urandom};
      low      = {near_value(base_src), near_value(base_dst)};
      high     = {near_value(base_src), near_value(base_dst)};
      // Mostly keep the fences ordered; an inverted pair is still legal
      if (low > high && $urandom_range(0, 3) != 0) begin
        swap = low;
        low  = high;
        high = swap;
      end
      if (s == 5) low = '1;
      case (s)
        0: segs = 5'd1;
        1: segs = 5'd16;
        2: segs = 5'd2;
        3: segs = 5'd15;
        default: segs = SEGS_W'($urandom_range(0, 31));
      endcase
      program_gate(low, high, GATE_W'($urandom_range(0, 65535)), segs);

      burst = $urandom_range(1, 40);
      for (int n = 0; n < PER_SETUP; n++) begin
        issue(random_command(base_src, base_dst), 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          // Two setups run back to back with no idling at all
          if (s != 3 && s != 7) begin
            if ($urandom_range(0, 15) == 0) hold_until_drained();
            else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20));
          end
        end
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (outcomes_due.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", outcomes_due.size()));

    $display("Run covered %0d commands (%0d route, %0d set, %0d read, %0d unused) under %0d setups",
             commands_sent, op_count[OP_ROUTE], op_count[OP_SET], op_count[OP_READ],
             op_count[OP_UNUSED], setups_written);
    $display("Routes went ahead %0d, left %0d, right %0d, invalid %0d; %0d results, %0d mismatches",
             dir_count[DIR_AHEAD], dir_count[DIR_LEFT], dir_count[DIR_RIGHT],
             dir_count[DIR_INVALID], results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
